// File: rtl/core/sorted_key_table_core_macros.svh
// ----------------------------------------------------------------------------
// sorted key table assertion macros
// shared concurrent assertion forms for the table core
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_TABLE_CORE_MACROS_SVH
`define SORTED_KEY_TABLE_CORE_MACROS_SVH

// same-cycle implication
`define SKT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sorted key table assertion failed");

// next-cycle implication
`define SKT_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sorted key table assertion failed");

`endif

// File: rtl/core/skt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_pkg
// constants, codes and types shared by the sorted key table core
// ----------------------------------------------------------------------------
package skt_pkg;

   localparam int CAPACITY    = 64;
   localparam int HANDLE_BITS = 16;
   localparam int KEY_W       = 32;
   localparam int IDX_W       = $clog2(CAPACITY);
   localparam int CNT_W       = $clog2(CAPACITY + 1);
   localparam int ENTRY_W     = KEY_W + HANDLE_BITS;

   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_REMOVE = 2'd1;
   localparam logic [1:0] MODE_LOOKUP = 2'd2;

   localparam logic [2:0] STAT_OK        = 3'd0;
   localparam logic [2:0] STAT_NOT_FOUND = 3'd1;
   localparam logic [2:0] STAT_DUPLICATE = 3'd2;
   localparam logic [2:0] STAT_FULL      = 3'd3;
   localparam logic [2:0] STAT_EMPTY     = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_CMP,
      ST_DECIDE,
      ST_SHIFT,
      ST_RESULT
   } ctrl_state_type;

   typedef struct packed {
      logic [1:0]              mode;
      logic signed [KEY_W-1:0] key;
      logic [HANDLE_BITS-1:0]  handle;
   } op_type;

   typedef struct packed {
      logic [2:0]             status;
      logic [HANDLE_BITS-1:0] handle;
      logic [CNT_W-1:0]       count;
   } result_type;

endpackage

// File: rtl/core/skt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
module skt_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 48
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// File: rtl/core/skt_ctrl.sv
`timescale 1ns / 1ps
`include "sorted_key_table_core_macros.svh"
// ----------------------------------------------------------------------------
// skt_ctrl
// binary search over the sorted entry ram, then, for an insert or a remove, a read-modify-write shift
// ----------------------------------------------------------------------------
module skt_ctrl
   import skt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  op_type     op,
   output logic       ready,
   output logic       res_valid,
   input  logic       res_take,
   output result_type res
);

   ctrl_state_type state_ff, state_in;
   op_type         op_ff, op_in;
   logic [CNT_W-1:0] occ_ff, occ_in;
   logic [CNT_W-1:0] lo_ff, lo_in;
   logic [CNT_W-1:0] hi_ff, hi_in;
   logic [IDX_W-1:0] mid_ff, mid_in;
   logic             found_ff, found_in;
   logic [HANDLE_BITS-1:0] fhandle_ff, fhandle_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             pend_ff, pend_in;
   logic [IDX_W-1:0] pend_addr_ff, pend_addr_in;
   logic [2:0]       status_ff, status_in;

   logic               rd_en, wr_en;
   logic [IDX_W-1:0]   rd_addr, wr_addr;
   logic [ENTRY_W-1:0] rd_data, wr_data;
   logic [CNT_W:0]     mid_sum;
   logic signed [KEY_W-1:0] rd_key;

   skt_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (ENTRY_W)
   ) u_ram (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign rd_key  = rd_data[ENTRY_W-1:HANDLE_BITS];

   assign ready      = (state_ff == ST_IDLE);
   assign res_valid  = (state_ff == ST_RESULT);
   assign res.status = status_ff;
   assign res.handle = fhandle_ff;
   assign res.count  = occ_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         occ_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         occ_ff   <= occ_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      found_ff     <= found_in;
      fhandle_ff   <= fhandle_in;
      cnt_ff       <= cnt_in;
      idx_ff       <= idx_in;
      pend_addr_ff <= pend_addr_in;
      status_ff    <= status_in;
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      occ_in       = occ_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      found_in     = found_ff;
      fhandle_in   = fhandle_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      status_in    = status_ff;
      rd_en        = 1'b0;
      rd_addr      = mid_ff;
      wr_en        = 1'b0;
      wr_addr      = pend_addr_ff;
      wr_data      = rd_data;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in      = op;
               lo_in      = '0;
               hi_in      = occ_ff;
               found_in   = 1'b0;
               fhandle_in = '0;
               pend_in    = 1'b0;
               if (op.mode == MODE_INSERT) begin
                  if (occ_ff == CNT_W'(CAPACITY)) begin
                     status_in = STAT_FULL;
                     state_in  = ST_RESULT;
                  end else begin
                     state_in = ST_SEARCH;
                  end
               end else if (op.mode == MODE_REMOVE || op.mode == MODE_LOOKUP) begin
                  if (occ_ff == '0) begin
                     status_in = STAT_EMPTY;
                     state_in  = ST_RESULT;
                  end else begin
                     state_in = ST_SEARCH;
                  end
               end else begin
                  status_in = STAT_NOT_FOUND;
                  state_in  = ST_RESULT;
               end
            end
         end

         ST_SEARCH: begin
            if (lo_ff < hi_ff) begin
               rd_en    = 1'b1;
               rd_addr  = mid_sum[IDX_W:1];
               mid_in   = mid_sum[IDX_W:1];
               state_in = ST_CMP;
            end else begin
               state_in = ST_DECIDE;
            end
         end

         ST_CMP: begin
            if (rd_key < op_ff.key) begin
               lo_in = CNT_W'(mid_ff) + 1'b1;
            end else begin
               hi_in = CNT_W'(mid_ff);
            end
            // keys are unique, so a hit is the lower bound itself
            if (rd_key == op_ff.key) begin
               found_in   = 1'b1;
               fhandle_in = rd_data[HANDLE_BITS-1:0];
            end
            state_in = ST_SEARCH;
         end

         ST_DECIDE: begin
            status_in = STAT_OK;
            state_in  = ST_RESULT;
            if (op_ff.mode == MODE_INSERT) begin
               if (found_ff) begin
                  status_in  = STAT_DUPLICATE;
                  fhandle_in = '0;
               end else begin
                  cnt_in   = occ_ff - lo_ff;
                  idx_in   = IDX_W'(occ_ff - 1'b1);
                  state_in = ST_SHIFT;
               end
            end else if (!found_ff) begin
               status_in = STAT_NOT_FOUND;
            end else if (op_ff.mode == MODE_REMOVE) begin
               cnt_in   = occ_ff - lo_ff - 1'b1;
               idx_in   = IDX_W'(lo_ff + 1'b1);
               state_in = ST_SHIFT;
            end
         end

         ST_SHIFT: begin
            // read one entry a cycle, write it one place over on the next
            if (pend_ff) begin
               wr_en = 1'b1;
            end
            if (cnt_ff != '0) begin
               rd_en   = 1'b1;
               rd_addr = idx_ff;
               cnt_in  = cnt_ff - 1'b1;
               pend_in = 1'b1;
               if (op_ff.mode == MODE_INSERT) begin
                  idx_in       = idx_ff - 1'b1;
                  pend_addr_in = idx_ff + 1'b1;
               end else begin
                  idx_in       = idx_ff + 1'b1;
                  pend_addr_in = idx_ff - 1'b1;
               end
            end else if (pend_ff) begin
               pend_in = 1'b0;
            end else begin
               if (op_ff.mode == MODE_INSERT) begin
                  wr_en   = 1'b1;
                  wr_addr = IDX_W'(lo_ff);
                  wr_data = {op_ff.key, op_ff.handle};
                  occ_in  = occ_ff + 1'b1;
               end else begin
                  occ_in  = occ_ff - 1'b1;
               end
               state_in = ST_RESULT;
            end
         end

         ST_RESULT: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `SKT_ASSERT_IMP(a_occ_bound, clock, reset, 1'b1, occ_ff <= CNT_W'(CAPACITY))
   `SKT_ASSERT_NXT(a_occ_only_after_shift, clock, reset,
      occ_in != occ_ff, $past(state_ff) == ST_SHIFT)
   `SKT_ASSERT_IMP(a_no_insert_when_full, clock, reset,
      state_ff == ST_SHIFT && op_ff.mode == MODE_INSERT, occ_ff < CNT_W'(CAPACITY))
   `SKT_ASSERT_IMP(a_write_only_in_shift, clock, reset, wr_en, state_ff == ST_SHIFT)

endmodule

// File: rtl/core/sorted_key_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_table_core
// sorted key/handle table with insert, remove and lookup over streaming ports
// ----------------------------------------------------------------------------
// usage:
//   req_* takes one operation per beat: mode, signed key and record handle.
//   rsp_* returns one beat per operation: status, found handle, entry count.
//   entries live in one ram in ascending signed key order; an operation runs
//   a binary search, each probe a ram read and then a compare, then ends
//   the search and decides. insert then moves every entry from the insert
//   position up by one place, and remove every entry above the hit position
//   down by one place, one entry a cycle through the single read and write
//   port; a drain step writes the last moved entry, then a finish step
//   writes the new entry on insert and updates the count (only the finish
//   step when nothing moves).
//   a result sits in an output register; the core accepts and works on the
//   next operation while that beat waits, and holds its own result until
//   the register frees, so a stalled receiver stops the core after one item.
//   reset empties the table at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_key_table_core
   import skt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,  // mode[1:0], key[33:2], record_handle[49:34]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata   // status[2:0], found_handle[18:3], entry_count[25:19]
);

   op_type     op;
   result_type res;
   logic       start, res_valid, res_take, ctrl_ready;

   logic [HANDLE_BITS+15:0] in_handle_ext;
   logic [HANDLE_BITS+15:0] out_handle_ext;
   logic [CNT_W+6:0]        out_count_ext;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  status_ff;
   logic [15:0] handle_ff;
   logic [6:0]  count_ff;

   assign in_handle_ext = {{HANDLE_BITS{1'b0}}, req_tdata[49:34]};
   assign op.mode   = req_tdata[1:0];
   assign op.key    = req_tdata[33:2];
   assign op.handle = in_handle_ext[HANDLE_BITS-1:0];

   assign req_tready = ctrl_ready;
   assign start      = req_tvalid && ctrl_ready;

   skt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .op        (op),
      .ready     (ctrl_ready),
      .res_valid (res_valid),
      .res_take  (res_take),
      .res       (res)
   );

   assign out_handle_ext = {16'd0, res.handle};
   assign out_count_ext  = {7'd0, res.count};

   // output register frees when empty or when its beat is taken
   assign res_take     = res_valid && (!rsp_valid_ff || rsp_tready);
   assign rsp_valid_in = res_take || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         status_ff <= res.status;
         handle_ff <= out_handle_ext[15:0];
         count_ff  <= out_count_ext[6:0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, count_ff, handle_ff, status_ff};

endmodule
